[design/lcrs_pkg.sv]
// Shared types, codes and widths of the call/return stack unit.
package lcrs_pkg;

    localparam int SCRIPT_W = 8;
    localparam int PC_W = 16;
    localparam int CMD_W = 3;
    localparam int STATUS_W = 2;
    localparam int FRAME_W = SCRIPT_W + PC_W;

    localparam int P_STACK_DEPTH = 16;
    localparam int P_SCRIPT_COUNT = 256;

    typedef enum logic [CMD_W-1:0] {
        CMD_CALL = 3'd0,
        CMD_RETURN = 3'd1,
        CMD_SET_ENTRY = 3'd2,
        CMD_CLEAR_ENTRY = 3'd3,
        CMD_ROOM_RESET = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK = 2'd0,
        STS_UNDERFLOW = 2'd1,
        STS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Write request to the entry-point table.
    typedef struct packed {
        logic                en;
        logic [SCRIPT_W-1:0] script;
        logic [PC_W-1:0]     data;
    } t_ent_wr;

endpackage

[design/lcrs_entry_mem.sv]
// Entry-point table: synchronous memory with per-entry valid bits cleared at reset.
module lcrs_entry_mem
    import lcrs_pkg::*;
#(
    parameter int SCRIPT_COUNT = P_SCRIPT_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [SCRIPT_W-1:0] i_rd_script,
    output logic [PC_W-1:0]     o_rd_data,
    input  t_ent_wr             i_wr
);
    localparam int AW = $clog2(SCRIPT_COUNT);

    logic [PC_W-1:0]         r_mem [SCRIPT_COUNT];
    logic [SCRIPT_COUNT-1:0] r_valid;
    logic [PC_W-1:0]         r_rd_data;
    logic                    r_rd_ok;
    logic                    rd_in_range;
    logic                    wr_in_range;
    logic [AW-1:0]           rd_idx;
    logic [AW-1:0]           wr_idx;

    // Script numbers beyond the table read as zero and are never written.
    assign rd_in_range = {1'b0, i_rd_script} < (SCRIPT_W+1)'(SCRIPT_COUNT);
    assign wr_in_range = {1'b0, i_wr.script} < (SCRIPT_W+1)'(SCRIPT_COUNT);
    assign rd_idx = i_rd_script[AW-1:0];
    assign wr_idx = i_wr.script[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in_range) begin
            r_mem[wr_idx] <= i_wr.data;
        end
        r_rd_data <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr.en && wr_in_range) begin
                r_valid[wr_idx] <= 1'b1;
            end
            r_rd_ok <= rd_in_range && r_valid[rd_idx];
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

[design/lcrs_stack_mem.sv]
// Call stack storage: one write port, one registered read port.
module lcrs_stack_mem
    import lcrs_pkg::*;
#(
    parameter int STACK_DEPTH = P_STACK_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_wr_addr,
    input  logic [FRAME_W-1:0]             i_wr_data,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_rd_addr,
    output logic [FRAME_W-1:0]             o_rd_data
);
    logic [FRAME_W-1:0] r_mem [STACK_DEPTH];
    logic [FRAME_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/logic_call_return_stack_unit.sv]
// Call/return stack unit: top level with command sequencer and both memories.
//
// Usage: the interpreter presents a command word (i_cmd, i_target_script,
// i_current_pc) with start high; the word is taken at a clock edge where busy
// is low. The unit reads the entry-point table and the call stack in the
// accept cycle, evaluates the command in the following cycle while writing
// back either memory, and presents the result word on the o_ ports with
// o_valid high for exactly one cycle after that.
// One word is in flight at a time: busy stays high during the evaluate cycle,
// so a new word cannot be taken until the previous result is shown, and can
// be taken in the same cycle that it is shown. The evaluate cycle follows the
// accept cycle because both memories have registered read ports.
// The receiver cannot stall; each result is taken in the cycle it appears.
// A synchronous active-low reset empties the stack, selects script 0 and
// clears the entry-point table through its valid bits, so the unit accepts
// commands in the first cycle after reset.
module logic_call_return_stack_unit
    import lcrs_pkg::*;
#(
    parameter int STACK_DEPTH = P_STACK_DEPTH,
    parameter int SCRIPT_COUNT = P_SCRIPT_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [SCRIPT_W-1:0] i_target_script,
    input  logic [PC_W-1:0]     i_current_pc,
    output logic                o_valid,
    output logic [SCRIPT_W-1:0] o_active_script,
    output logic [PC_W-1:0]     o_next_pc,
    output logic                o_jump,
    output logic                o_cycle_done,
    output logic [STATUS_W-1:0] o_status
);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    t_state              r_state, n_state;
    logic [DW-1:0]       r_depth, n_depth;
    logic [SCRIPT_W-1:0] r_script, n_script;
    logic [CMD_W-1:0]    r_cmd;
    logic [SCRIPT_W-1:0] r_target;
    logic [PC_W-1:0]     r_pc;

    logic                r_valid, n_valid;
    logic [SCRIPT_W-1:0] r_out_script, n_out_script;
    logic [PC_W-1:0]     r_out_pc, n_out_pc;
    logic                r_out_jump, n_out_jump;
    logic                r_out_done, n_out_done;
    t_status             r_out_status, n_out_status;

    logic                accept;
    logic [SCRIPT_W-1:0] ent_rd_script;
    logic [PC_W-1:0]     ent_rd_data;
    t_ent_wr             ent_wr;
    logic                stk_wr_en;
    logic [IW-1:0]       stk_wr_addr;
    logic [FRAME_W-1:0]  stk_wr_data;
    logic [IW-1:0]       stk_rd_addr;
    logic [FRAME_W-1:0]  stk_rd_data;
    logic [DW-1:0]       depth_minus_one;

    assign accept = start && (r_state == ST_IDLE);
    assign busy = (r_state != ST_IDLE);

    // Reads are issued in the accept cycle; the top of stack is depth minus one.
    assign ent_rd_script = (t_cmd'(i_cmd) == CMD_ROOM_RESET) ? '0 : i_target_script;
    assign depth_minus_one = r_depth - DW'(1);
    assign stk_rd_addr = depth_minus_one[IW-1:0];

    lcrs_entry_mem #(
        .SCRIPT_COUNT(SCRIPT_COUNT)
    ) u_entry_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_script(ent_rd_script),
        .o_rd_data  (ent_rd_data),
        .i_wr       (ent_wr)
    );

    lcrs_stack_mem #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack_mem (
        .i_clk    (i_clk),
        .i_wr_en  (stk_wr_en),
        .i_wr_addr(stk_wr_addr),
        .i_wr_data(stk_wr_data),
        .i_rd_addr(stk_rd_addr),
        .o_rd_data(stk_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_depth <= '0;
            r_script <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_script <= n_script;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_target <= i_target_script;
            r_pc <= i_current_pc;
        end
        r_out_script <= n_out_script;
        r_out_pc <= n_out_pc;
        r_out_jump <= n_out_jump;
        r_out_done <= n_out_done;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        n_script = r_script;
        n_valid = 1'b0;
        n_out_script = r_out_script;
        n_out_pc = r_out_pc;
        n_out_jump = r_out_jump;
        n_out_done = r_out_done;
        n_out_status = r_out_status;
        ent_wr = '0;
        stk_wr_en = 1'b0;
        stk_wr_addr = r_depth[IW-1:0];
        stk_wr_data = {r_script, r_pc};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_valid = 1'b1;
                n_out_pc = '0;
                n_out_jump = 1'b0;
                n_out_done = 1'b0;
                n_out_status = STS_OK;
                case (t_cmd'(r_cmd))
                    CMD_CALL: begin
                        if (r_depth >= DW'(STACK_DEPTH)) begin
                            n_out_status = STS_OVERFLOW;
                        end else begin
                            stk_wr_en = 1'b1;
                            n_depth = r_depth + DW'(1);
                            n_script = r_target;
                            n_out_pc = ent_rd_data;
                            n_out_jump = 1'b1;
                        end
                    end
                    CMD_RETURN: begin
                        if (r_script == '0) begin
                            n_out_done = 1'b1;
                        end else if (r_depth == '0) begin
                            n_out_status = STS_UNDERFLOW;
                        end else begin
                            n_depth = depth_minus_one;
                            n_script = stk_rd_data[FRAME_W-1:PC_W];
                            n_out_pc = stk_rd_data[PC_W-1:0];
                            n_out_jump = 1'b1;
                        end
                    end
                    CMD_SET_ENTRY: begin
                        ent_wr.en = 1'b1;
                        ent_wr.script = r_script;
                        ent_wr.data = r_pc;
                    end
                    CMD_CLEAR_ENTRY: begin
                        ent_wr.en = 1'b1;
                        ent_wr.script = r_script;
                        ent_wr.data = '0;
                    end
                    CMD_ROOM_RESET: begin
                        n_script = '0;
                        n_depth = '0;
                        n_out_pc = ent_rd_data;
                        n_out_jump = 1'b1;
                    end
                    default: begin
                    end
                endcase
                n_out_script = n_script;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid = r_valid;
    assign o_active_script = r_out_script;
    assign o_next_pc = r_out_pc;
    assign o_jump = r_out_jump;
    assign o_cycle_done = r_out_done;
    assign o_status = r_out_status;

endmodule

[design/lcrs_checker.sv]
// Port-level checks of the call/return stack unit, bound to its top level.
module lcrs_checker
    import lcrs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic [CMD_W-1:0]    i_cmd,
    input logic [SCRIPT_W-1:0] i_target_script,
    input logic [PC_W-1:0]     i_current_pc,
    input logic                o_valid,
    input logic [SCRIPT_W-1:0] o_active_script,
    input logic [PC_W-1:0]     o_next_pc,
    input logic                o_jump,
    input logic                o_cycle_done,
    input logic [STATUS_W-1:0] o_status
);
    // An accepted word occupies the unit for the evaluate cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // The evaluate cycle always ends in exactly one result word.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_valid)
        else $error("evaluate cycle did not produce a result");

    // Results are single-cycle strobes; no two in a row.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    // Without a jump the reported pc is zero.
    a_no_jump_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_jump |-> o_next_pc == '0)
        else $error("next pc nonzero without jump");

    // Cycle completion only comes from script 0 and carries no jump or error.
    a_cycle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cycle_done |->
            !o_jump && o_status == STS_OK && o_active_script == '0)
        else $error("inconsistent cycle-done result");

endmodule

bind logic_call_return_stack_unit lcrs_checker u_lcrs_checker (.*);
